>>> hw/rtl/pse_pkg.sv
package pse_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_OUT = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_W = 33;
	localparam int ANGLE_W = 34;

	// cordic start value, gain 0.60725 in q2.30
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EXPAND = 1'b1;

	// one queued transaction
	typedef struct packed {
		logic kind;
		logic [3:0] slot;
		logic signed [31:0] step_forward;
		logic signed [31:0] step_side;
		logic signed [15:0] step_turn;
		logic [31:0] step_cost;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_heading;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_ROT,
		B_READ,
		B_MUL,
		B_SUM,
		B_OUT
	} back_state_t;

	// atan(2^-i) in units of pi / 2^31
	function automatic logic signed [ANGLE_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [ANGLE_W-1:0] r;
		unique case (i)
			4'd0: r = 34'sd536870912;
			4'd1: r = 34'sd316933406;
			4'd2: r = 34'sd167458907;
			4'd3: r = 34'sd85004756;
			4'd4: r = 34'sd42667331;
			4'd5: r = 34'sd21354465;
			4'd6: r = 34'sd10679838;
			4'd7: r = 34'sd5340245;
			4'd8: r = 34'sd2670163;
			4'd9: r = 34'sd1335087;
			4'd10: r = 34'sd667544;
			4'd11: r = 34'sd333772;
			4'd12: r = 34'sd166886;
			4'd13: r = 34'sd83443;
			4'd14: r = 34'sd41722;
			default: r = 34'sd20861;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/pse_front.sv
module pse_front import pse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	output head_t head,
	input logic pop
);

	localparam int QD = 2;

	cmd_t q_mem_q [QD];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	// two-entry transaction queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= push_cmd;
	end

	assign full = (cnt_q == 2'(QD));
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = q_mem_q[rd_ptr_q];

endmodule

>>> hw/rtl/pse_cordic.sv
module pse_cordic import pse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] heading,
	output logic done,
	output logic signed [CORDIC_W-1:0] cos_o,
	output logic signed [CORDIC_W-1:0] sin_o
);

	logic run_q;
	logic [3:0] i_q;
	logic flip_q;
	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [ANGLE_W-1:0] z_q;
	logic done_q;
	logic signed [CORDIC_W-1:0] x_n, y_n;
	logic signed [ANGLE_W-1:0] z_n;
	logic signed [15:0] h_s;
	logic fold;
	logic [15:0] h_f;

	// fold heading into the right half plane
	always_comb begin
		h_s = signed'(heading);
		fold = (h_s > 16'sd16384) || (h_s < -16'sd16384);
		h_f = fold ? (heading ^ 16'h8000) : heading;
	end

	// one rotation stage per cycle
	always_comb begin
		if (z_q >= 0) begin
			x_n = x_q - (y_q >>> i_q);
			y_n = y_q + (x_q >>> i_q);
			z_n = z_q - atan_lut(i_q);
		end else begin
			x_n = x_q + (y_q >>> i_q);
			y_n = y_q - (x_q >>> i_q);
			z_n = z_q + atan_lut(i_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= 4'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q <= 4'd0;
			end else if (run_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'(CORDIC_STAGES - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= {{(ANGLE_W-32){h_f[15]}}, h_f, 16'd0};
			flip_q <= fold;
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
			if (i_q == 4'(CORDIC_STAGES - 1)) begin
				cos_o <= flip_q ? -x_n : x_n;
				sin_o <= flip_q ? -y_n : y_n;
			end
		end
	end

	assign done = done_q;

endmodule

>>> hw/rtl/pse_back.sv
module pse_back import pse_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input head_t head,
	output logic pop,
	input logic [4:0] entries_in_use,
	output logic result_strobe,
	output logic [3:0] entry_index,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [15:0] next_heading,
	output logic [31:0] next_cost,
	output logic clipped,
	output logic last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LIM = (TABLE_DEPTH < MAX_OUT) ? TABLE_DEPTH : MAX_OUT;

	back_state_t state_q, state_d;

	logic [31:0] mem_fwd [TABLE_DEPTH];
	logic [31:0] mem_side [TABLE_DEPTH];
	logic [15:0] mem_turn [TABLE_DEPTH];
	logic [31:0] mem_cost [TABLE_DEPTH];

	logic [4:0] n_q, cnt_q, n_lim;
	logic signed [31:0] px_q, py_q;
	logic [15:0] ph_q;
	logic signed [31:0] fwd_s1, side_s1;
	logic [15:0] turn_s1, turn_s2, turn_s3;
	logic [31:0] cost_s1, cost_s2, cost_s3;
	logic signed [64:0] p_fc_s2, p_ss_s2, p_fs_s2, p_sc_s2;
	logic signed [35:0] dx_s3, dy_s3;
	logic signed [65:0] sx, sy;
	logic signed [36:0] nx, ny;
	logic signed [CORDIC_W-1:0] cos_v, sin_v;
	logic cordic_done;
	logic is_load, is_expand, do_write, cordic_start;
	logic [8:0] wr_addr, rd_addr;
	logic strobe_q;

	pse_cordic u_cordic (
		.clk (clk),
		.arst_n (arst_n),
		.start (cordic_start),
		.heading (head.cmd.pose_heading),
		.done (cordic_done),
		.cos_o (cos_v),
		.sin_o (sin_v)
	);

	assign n_lim = (entries_in_use > 5'(LIM)) ? 5'(LIM) : entries_in_use;
	assign wr_addr = 9'(head.cmd.slot);
	assign rd_addr = 9'(cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (head.valid && head.cmd.kind == KIND_EXPAND && n_lim != 5'd0)
					state_d = B_ROT;
			end
			B_ROT: if (cordic_done) state_d = B_READ;
			B_READ: state_d = B_MUL;
			B_MUL: state_d = B_SUM;
			B_SUM: state_d = B_OUT;
			B_OUT: state_d = (cnt_q + 5'd1 == n_q) ? B_IDLE : B_READ;
			default: state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		is_load = head.valid && head.cmd.kind == KIND_LOAD;
		is_expand = head.valid && head.cmd.kind == KIND_EXPAND;
		pop = (state_q == B_IDLE) && head.valid;
		do_write = (state_q == B_IDLE) && is_load && (wr_addr < 9'(TABLE_DEPTH));
		cordic_start = (state_q == B_IDLE) && is_expand && n_lim != 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= 5'd0;
			n_q <= 5'd0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= (state_q == B_OUT);
			if (cordic_start) begin
				n_q <= n_lim;
				cnt_q <= 5'd0;
			end else if (state_q == B_OUT) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	// primitive table
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_fwd[wr_addr[AW-1:0]] <= head.cmd.step_forward;
			mem_side[wr_addr[AW-1:0]] <= head.cmd.step_side;
			mem_turn[wr_addr[AW-1:0]] <= head.cmd.step_turn;
			mem_cost[wr_addr[AW-1:0]] <= head.cmd.step_cost;
		end
		if (state_q == B_READ) begin
			fwd_s1 <= mem_fwd[rd_addr[AW-1:0]];
			side_s1 <= mem_side[rd_addr[AW-1:0]];
			turn_s1 <= mem_turn[rd_addr[AW-1:0]];
			cost_s1 <= mem_cost[rd_addr[AW-1:0]];
		end
	end

	// round and sum of the rotated step
	always_comb begin
		sx = 66'(p_fc_s2) - 66'(p_ss_s2) + 66'sd536870912;
		sy = 66'(p_fs_s2) + 66'(p_sc_s2) + 66'sd536870912;
		nx = 37'(px_q) + 37'(dx_s3);
		ny = 37'(py_q) + 37'(dy_s3);
	end

	// per-slot datapath
	always_ff @(posedge clk) begin
		if (cordic_start) begin
			px_q <= head.cmd.pose_x;
			py_q <= head.cmd.pose_y;
			ph_q <= head.cmd.pose_heading;
		end
		if (state_q == B_MUL) begin
			p_fc_s2 <= fwd_s1 * cos_v;
			p_ss_s2 <= side_s1 * sin_v;
			p_fs_s2 <= fwd_s1 * sin_v;
			p_sc_s2 <= side_s1 * cos_v;
			turn_s2 <= turn_s1;
			cost_s2 <= cost_s1;
		end
		if (state_q == B_SUM) begin
			dx_s3 <= sx[65:30];
			dy_s3 <= sy[65:30];
			turn_s3 <= turn_s2;
			cost_s3 <= cost_s2;
		end
		if (state_q == B_OUT) begin
			entry_index <= cnt_q[3:0];
			if (nx > 37'sd2147483647)
				next_x <= 32'sh7fffffff;
			else if (nx < -37'sd2147483648)
				next_x <= 32'sh80000000;
			else
				next_x <= nx[31:0];
			if (ny > 37'sd2147483647)
				next_y <= 32'sh7fffffff;
			else if (ny < -37'sd2147483648)
				next_y <= 32'sh80000000;
			else
				next_y <= ny[31:0];
			clipped <= (nx > 37'sd2147483647) || (nx < -37'sd2147483648) ||
				(ny > 37'sd2147483647) || (ny < -37'sd2147483648);
			next_heading <= ph_q + turn_s3;
			next_cost <= cost_s3;
			last <= (cnt_q + 5'd1 == n_q);
		end
	end

	assign result_strobe = strobe_q;

endmodule

>>> hw/rtl/pose_successor_expander.sv
// channel  | direction | handshake            | payload
// command  | in        | start, busy          | kind, slot, step_*, pose_*
// config   | in        | cfg_valid, cfg_ready | cfg_data (entries_in_use)
// result   | out       | result_strobe        | entry_index, next_*, clipped, last
//
// a load writes the table from the back end's idle state; an expand first
// computes sine/cosine (16-stage iterative cordic), then for each slot runs the
// table read, multiply, round and saturate steps of the shared datapath.
// a two-entry queue sits in front; busy is high while it is full.
// reset clears control state only; the table is undefined until loaded.
// results are one-cycle strobes and cannot be held off by the receiver.
module pose_successor_expander import pse_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic kind,
	input logic [3:0] slot,
	input logic signed [31:0] step_forward,
	input logic signed [31:0] step_side,
	input logic signed [15:0] step_turn,
	input logic [31:0] step_cost,
	input logic signed [31:0] pose_x,
	input logic signed [31:0] pose_y,
	input logic signed [15:0] pose_heading,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [4:0] cfg_data,
	output logic result_strobe,
	output logic [3:0] entry_index,
	output logic signed [31:0] next_x,
	output logic signed [31:0] next_y,
	output logic signed [15:0] next_heading,
	output logic [31:0] next_cost,
	output logic clipped,
	output logic last
);

	logic [4:0] entries_in_use_q;
	cmd_t push_cmd;
	head_t head;
	logic pop, full;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entries_in_use_q <= 5'd0;
		else if (cfg_valid && cfg_ready)
			entries_in_use_q <= cfg_data;
	end

	always_comb begin
		push_cmd.kind = kind;
		push_cmd.slot = slot;
		push_cmd.step_forward = step_forward;
		push_cmd.step_side = step_side;
		push_cmd.step_turn = step_turn;
		push_cmd.step_cost = step_cost;
		push_cmd.pose_x = pose_x;
		push_cmd.pose_y = pose_y;
		push_cmd.pose_heading = pose_heading;
	end

	assign busy = full;

	pse_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.push (start && !busy),
		.push_cmd (push_cmd),
		.full (full),
		.head (head),
		.pop (pop)
	);

	pse_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (head),
		.pop (pop),
		.entries_in_use (entries_in_use_q),
		.result_strobe (result_strobe),
		.entry_index (entry_index),
		.next_x (next_x),
		.next_y (next_y),
		.next_heading (next_heading),
		.next_cost (next_cost),
		.clipped (clipped),
		.last (last)
	);

endmodule

>>> hw/rtl/pse_checker.sv
module pse_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic result_strobe,
	input logic [3:0] entry_index,
	input logic last
);

	// config writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready) else $error("config write refused");

	// results never come in adjacent cycles
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe) else $error("results too close");

	// an unfinished expand gives the next slot after the read, multiply, sum and output states
	a_next_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> ##4
		(result_strobe && entry_index == $past(entry_index, 4) + 4'd1))
		else $error("missing or misordered result");

endmodule

bind pose_successor_expander pse_checker u_pse_checker (
	.clk (clk),
	.arst_n (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.result_strobe (result_strobe),
	.entry_index (entry_index),
	.last (last)
);
